[src/fit_policy_block_allocator_core_assert.svh]
// assertion macros used by the checker file
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define FPBA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define FPBA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/fpba_pkg.sv]
package fpba_pkg;

  // operation codes of an input beat
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_COMP  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // placement policies
  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  // result status codes
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_NOFIT = 2'd1;
  localparam logic [1:0] STS_FULL  = 2'd2;

  localparam int AMT_W   = 16;
  localparam int IDXO_W  = 4;
  localparam int TOTAL_W = 20;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 20'hFFFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic clr;
    logic eval;
  } pick_ctl_t;

endpackage

[src/fpba_table.sv]
module fpba_table #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 16,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/fpba_pick.sv]
module fpba_pick #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  fpba_pkg::pick_ctl_t  ctl,
  input  logic [1:0]           fit_mode,
  input  logic [15:0]          need,
  input  logic [SIZE_BITS-1:0] cand_size,
  input  logic [IDX_W-1:0]     cand_idx,
  output logic                 found,
  output logic [IDX_W-1:0]     pick_idx,
  output logic [SIZE_BITS-1:0] pick_size
);
  import fpba_pkg::*;

  localparam int CMP_W = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  logic                 found_r, found_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] size_r, size_nxt;
  logic                 fits, take;

  always_comb begin
    fits = (CMP_W'(cand_size) >= CMP_W'(need));
    case (fit_mode)
      FIT_FIRST: take = fits && !found_r;
      FIT_BEST:  take = fits && (!found_r || (cand_size < size_r));
      FIT_WORST: take = fits && (!found_r || (cand_size > size_r));
      default:   take = 1'b0;
    endcase
    found_nxt = found_r;
    idx_nxt   = idx_r;
    size_nxt  = size_r;
    if (ctl.clr) begin
      found_nxt = 1'b0;
    end else if (ctl.eval && take) begin
      found_nxt = 1'b1;
      idx_nxt   = cand_idx;
      size_nxt  = cand_size;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    size_r <= size_nxt;
  end

  assign found     = found_r;
  assign pick_idx  = idx_r;
  assign pick_size = size_r;

endmodule

[src/fit_policy_block_allocator_core.sv]
// free-block allocator with a selectable placement policy
//
// input channel: an operation beat (in_mode, in_amount) is taken on a rising
// edge with start high and busy low. load appends a block size, allocate
// searches the table, compact merges all free space into entry 0, clear
// empties the table
// result channel: one beat per operation, shown for a single cycle with
// out_valid high; the receiver cannot stall it, so it is just registered
// config: cfg_fit_mode is written on cfg_valid and cfg_ready, ready only idle
//
// timing: load, clear, and allocate or compact on an empty table give the
// result on the edge after the accept, and a new beat can follow at once.
// allocate and compact walk the table through the one read port of the
// size memory, one entry per cycle; busy stays high for the whole walk
// and falls as the result appears (first fit stops early)
// reset: table empty, total zero, policy first fit; the size memory itself
// is not cleared, only entries below the count are ever read
module fit_policy_block_allocator_core #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [15:0] in_amount,
  output logic        out_valid,
  output logic [1:0]  out_status,
  output logic [3:0]  out_block_index,
  output logic [19:0] out_total_free,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_fit_mode
);
  import fpba_pkg::*;

  localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
  localparam int TOT_W  = SIZE_BITS + CNT_W;
  localparam int AMX_W  = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
  localparam int TCMP_W = (TOT_W > TOTAL_W) ? TOT_W : TOTAL_W;

  // control state
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [TOT_W-1:0] sum_r, sum_nxt;    // exact sum of free sizes
  logic [1:0]       fit_r, fit_nxt;
  logic             iss_on_r, iss_on_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic             out_vld_r, out_vld_nxt;

  // payload
  logic [1:0]           op_r, op_nxt;
  logic [15:0]          amt_r, amt_nxt;
  logic [CNT_W-1:0]     iss_r, iss_nxt;
  logic [IDX_W-1:0]     chk_idx_r, chk_idx_nxt;
  logic [TOT_W-1:0]     acc_r, acc_nxt;   // compaction sum
  logic [1:0]           sts_r, sts_nxt;
  logic [IDXO_W-1:0]    oidx_r, oidx_nxt;
  logic [TOTAL_W-1:0]   otot_r, otot_nxt;

  // size memory ports
  logic                 wr_en, rd_en;
  logic [IDX_W-1:0]     wr_addr, rd_addr;
  logic [SIZE_BITS-1:0] wr_data, rd_data;

  // pick unit
  pick_ctl_t            pk_ctl;
  logic                 pk_found;
  logic [IDX_W-1:0]     pk_idx;
  logic [SIZE_BITS-1:0] pk_size;

  fpba_table #(
    .DEPTH  (MAX_BLOCKS),
    .DATA_W (SIZE_BITS),
    .ADDR_W (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  fpba_pick #(
    .SIZE_BITS (SIZE_BITS),
    .IDX_W     (IDX_W)
  ) u_pick (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (pk_ctl),
    .fit_mode  (fit_r),
    .need      (amt_r),
    .cand_size (rd_data),
    .cand_idx  (chk_idx_r),
    .found     (pk_found),
    .pick_idx  (pk_idx),
    .pick_size (pk_size)
  );

  always_comb begin
    logic [AMX_W-1:0]     amt_ext;
    logic [SIZE_BITS-1:0] ld_val;
    logic [SIZE_BITS-1:0] cmp_val;
    logic [TCMP_W-1:0]    tot_ext;
    logic                 last_chk;
    logic                 ff_stop;
    logic                 finish;

    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    sum_nxt     = sum_r;
    fit_nxt     = fit_r;
    iss_on_nxt  = iss_on_r;
    chk_vld_nxt = 1'b0;
    out_vld_nxt = 1'b0;
    op_nxt      = op_r;
    amt_nxt     = amt_r;
    iss_nxt     = iss_r;
    chk_idx_nxt = iss_r[IDX_W-1:0];
    acc_nxt     = acc_r;
    sts_nxt     = sts_r;
    oidx_nxt    = oidx_r;
    finish      = 1'b0;

    wr_en   = 1'b0;
    wr_addr = cnt_r[IDX_W-1:0];
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = iss_r[IDX_W-1:0];
    pk_ctl  = '{clr: 1'b0, eval: 1'b0};

    // load value saturates at the widest size a table entry holds
    amt_ext = AMX_W'(in_amount);
    ld_val  = (amt_ext > AMX_W'({SIZE_BITS{1'b1}})) ? {SIZE_BITS{1'b1}}
                                                    : amt_ext[SIZE_BITS-1:0];
    // compacted block saturates the same way
    cmp_val = (acc_r > TOT_W'({SIZE_BITS{1'b1}})) ? {SIZE_BITS{1'b1}}
                                                  : acc_r[SIZE_BITS-1:0];

    last_chk = chk_vld_r && (CNT_W'(chk_idx_r) == (cnt_r - CNT_W'(1)));
    ff_stop  = (op_r == OP_ALLOC) && (fit_r == FIT_FIRST) && pk_found;

    if (cfg_valid && (state_r == ST_IDLE)) begin
      fit_nxt = cfg_fit_mode;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt     = in_mode;
          amt_nxt    = in_amount;
          iss_nxt    = '0;
          iss_on_nxt = 1'b1;
          acc_nxt    = '0;
          sts_nxt    = STS_OK;
          oidx_nxt   = '0;
          unique case (in_mode)
            OP_LOAD: begin
              finish = 1'b1;
              if (cnt_r >= CNT_W'(MAX_BLOCKS)) begin
                sts_nxt = STS_FULL;
              end else begin
                wr_en   = 1'b1;
                wr_addr = cnt_r[IDX_W-1:0];
                wr_data = ld_val;
                cnt_nxt = cnt_r + CNT_W'(1);
                sum_nxt = sum_r + TOT_W'(ld_val);
              end
            end
            OP_ALLOC: begin
              pk_ctl.clr = 1'b1;
              if (cnt_r == '0) begin
                finish  = 1'b1;
                sts_nxt = STS_NOFIT;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_COMP: begin
              if (cnt_r == '0) begin
                // empty table turns into one empty block
                finish  = 1'b1;
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '0;
                cnt_nxt = CNT_W'(1);
                sum_nxt = '0;
              end else begin
                state_nxt = ST_SCAN;
              end
            end
            OP_CLEAR: begin
              finish  = 1'b1;
              cnt_nxt = '0;
              sum_nxt = '0;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // read stage: one entry per cycle up to the count
        if (iss_on_r) begin
          rd_en   = 1'b1;
          rd_addr = iss_r[IDX_W-1:0];
          iss_nxt = iss_r + CNT_W'(1);
          chk_vld_nxt = 1'b1;
          if (iss_r == (cnt_r - CNT_W'(1))) begin
            iss_on_nxt = 1'b0;
          end
        end
        // check stage: data for chk_idx_r is on the memory output
        if (chk_vld_r) begin
          if (op_r == OP_ALLOC) begin
            pk_ctl.eval = 1'b1;
          end else begin
            acc_nxt = acc_r + TOT_W'(rd_data);
          end
        end
        if (last_chk || ff_stop) begin
          state_nxt   = ST_FIN;
          iss_on_nxt  = 1'b0;
          chk_vld_nxt = 1'b0;
        end
      end

      ST_FIN: begin
        // write back the one modified entry; no read is in flight here
        finish    = 1'b1;
        state_nxt = ST_IDLE;
        if (op_r == OP_ALLOC) begin
          if (pk_found) begin
            wr_en    = 1'b1;
            wr_addr  = pk_idx;
            wr_data  = pk_size - SIZE_BITS'(amt_r);
            sum_nxt  = sum_r - TOT_W'(amt_r);
            oidx_nxt = IDXO_W'(pk_idx);
          end else begin
            sts_nxt = STS_NOFIT;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = '0;
          wr_data = cmp_val;
          cnt_nxt = CNT_W'(1);
          sum_nxt = TOT_W'(cmp_val);
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // total reported at 20 bits, saturating
    tot_ext  = TCMP_W'(sum_nxt);
    otot_nxt = (tot_ext > TCMP_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_ext[TOTAL_W-1:0];
    if (finish) begin
      out_vld_nxt = 1'b1;
    end else begin
      otot_nxt = otot_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      sum_r     <= '0;
      fit_r     <= FIT_FIRST;
      iss_on_r  <= 1'b0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      sum_r     <= sum_nxt;
      fit_r     <= fit_nxt;
      iss_on_r  <= iss_on_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    amt_r     <= amt_nxt;
    iss_r     <= iss_nxt;
    chk_idx_r <= chk_idx_nxt;
    acc_r     <= acc_nxt;
    sts_r     <= sts_nxt;
    oidx_r    <= oidx_nxt;
    otot_r    <= otot_nxt;
  end

  assign busy            = (state_r != ST_IDLE);
  assign cfg_ready       = (state_r == ST_IDLE);
  assign out_valid       = out_vld_r;
  assign out_status      = sts_r;
  assign out_block_index = oidx_r;
  assign out_total_free  = otot_r;

endmodule

[src/fpba_checker.sv]
`include "fit_policy_block_allocator_core_assert.svh"

module fpba_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [1:0] out_status,
  input logic [3:0] out_block_index,
  input logic       cfg_ready
);
  import fpba_pkg::*;

  // an accepted beat either starts a walk or answers on the next edge
  `FPBA_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "beat lost after accept")

  // no result beat appears without a beat to answer
  `FPBA_ASSERT_NEXT(a_no_spurious, !start && !busy, !out_valid, "result without a request")

  // a walk always ends with its result
  `FPBA_ASSERT_NOW(a_walk_result, $fell(busy), out_valid, "walk ended without result")

  // only a grant carries a block index
  `FPBA_ASSERT_NOW(a_idx_grant, out_valid && out_status != STS_OK, out_block_index == 4'd0,
                   "index on a refused beat")

  // policy writes only taken while no walk runs
  `FPBA_ASSERT_NOW(a_cfg_idle, cfg_ready, !busy, "config ready during a walk")

endmodule

bind fit_policy_block_allocator_core fpba_checker u_fpba_checker (.*);

[tb/testbench.sv]
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import fpba_pkg::*;

  // policy code that the block treats as "nothing ever fits"
  localparam logic [1:0] FIT_UNUSED = 2'd3;
  localparam int TABLE_DEPTH = 16;
  localparam logic [15:0] SIZE_TOP = 16'hFFFF;
  // cycles with no beat moving on any channel before the run is abandoned
  localparam int STALL_LIMIT = 2000;
  // worst-case allocate on a full table plus some margin
  localparam int SETTLE_CYCLES = 25;
  localparam int ITEMS_PER_CHUNK = 104;

  // one result beat as the block should present it
  typedef struct packed {
    logic [1:0]         status;
    logic [IDXO_W-1:0]  idx;
    logic [TOTAL_W-1:0] total;
  } alloc_res_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        in_mode = OP_LOAD;
  logic [AMT_W-1:0]  in_amount = '0;
  logic              out_valid;
  logic [1:0]        out_status;
  logic [3:0]        out_block_index;
  logic [19:0]       out_total_free;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_fit_mode = FIT_FIRST;

  fit_policy_block_allocator_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_mode         (in_mode),
    .in_amount       (in_amount),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_block_index (out_block_index),
    .out_total_free  (out_total_free),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_fit_mode    (cfg_fit_mode)
  );

  // shadow copy of the allocator: table, fill level, running total, policy
  logic [AMT_W-1:0]   blk_size [TABLE_DEPTH];
  int                 blk_count = 0;
  logic [TOTAL_W-1:0] free_sum = '0;
  logic [1:0]         policy = FIT_FIRST;

  // results still owed by the block, oldest first
  alloc_res_t pending_res [$];

  int gap_pct = 0;
  int err_count = 0;
  int idle_cycles = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_cfg = 0;
  int n_by_op [4];
  int n_granted = 0;
  int n_nofit = 0;
  int n_full = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor: applies one operation to the shadow table and returns the beat
  // the block must answer with
  // ---------------------------------------------------------------------------
  function automatic alloc_res_t apply_op(input logic [1:0] op, input logic [AMT_W-1:0] amt);
    alloc_res_t res;
    int pick;
    int unsigned acc;
    logic [AMT_W-1:0] held;
    res.status = STS_OK;
    res.idx = '0;
    pick = -1;
    held = '0;
    acc = 0;
    case (op)
      OP_LOAD: begin
        // a full table refuses the block and keeps everything as it was
        if (blk_count >= TABLE_DEPTH) begin
          res.status = STS_FULL;
        end else begin
          blk_size[blk_count] = amt;
          blk_count++;
        end
      end
      OP_ALLOC: begin
        for (int i = 0; i < blk_count; i++) begin
          if (blk_size[i] >= amt) begin
            case (policy)
              // lowest qualifying index wins
              FIT_FIRST: if (pick < 0) pick = i;
              // strict compares so ties stay with the lower index
              FIT_BEST: begin
                if (pick < 0 || blk_size[i] < held) begin
                  pick = i;
                  held = blk_size[i];
                end
              end
              FIT_WORST: begin
                if (pick < 0 || blk_size[i] > held) begin
                  pick = i;
                  held = blk_size[i];
                end
              end
              // unused policy code: never a fit
              default: pick = -1;
            endcase
          end
        end
        if (pick < 0) begin
          res.status = STS_NOFIT;
        end else begin
          blk_size[pick] = blk_size[pick] - amt;
          res.idx = pick[IDXO_W-1:0];
        end
      end
      OP_COMP: begin
        // merge everything into entry 0, saturating at the entry width
        for (int i = 0; i < blk_count; i++) acc += blk_size[i];
        blk_size[0] = (acc > SIZE_TOP) ? SIZE_TOP : acc[AMT_W-1:0];
        blk_count = 1;
      end
      default: begin
        blk_count = 0;
      end
    endcase
    acc = 0;
    for (int i = 0; i < blk_count; i++) acc += blk_size[i];
    free_sum = (acc > TOTAL_MAX) ? TOTAL_MAX : acc[TOTAL_W-1:0];
    res.total = free_sum;
    return res;
  endfunction

  // one line per mismatch, and a count for the verdict
  task automatic note_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: optional idle gap, then hold the beat until busy is low at an edge
  // start is lowered only during an idle gap, so back-to-back beats keep it high
  // ---------------------------------------------------------------------------
  task automatic send_op(input logic [1:0] op, input logic [AMT_W-1:0] amt);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= op;
    in_amount <= amt;
    @(posedge clk);
    while (busy) @(posedge clk);
    // beat taken at this edge
    pending_res.push_back(apply_op(op, amt));
    n_sent++;
    n_by_op[op]++;
  endtask

  // drop start and let every owed result come back
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
  endtask

  // policy register write, only with the block idle
  task automatic set_policy(input logic [1:0] code);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_fit_mode <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    policy = code;
    n_cfg++;
  endtask

  // ---------------------------------------------------------------------------
  // result checker: every out_valid beat against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    alloc_res_t want;
    if (rst_n && out_valid) begin
      n_results++;
      if (pending_res.size() == 0) begin
        note_mismatch($sformatf("unexpected result beat status %0d index %0d total %0d",
                                out_status, out_block_index, out_total_free));
      end else begin
        want = pending_res.pop_front();
        case (want.status)
          STS_OK:    n_granted++;
          STS_NOFIT: n_nofit++;
          default:   n_full++;
        endcase
        if (out_status !== want.status || out_block_index !== want.idx ||
            out_total_free !== want.total)
          note_mismatch($sformatf("got status %0d index %0d total %0d, want %0d %0d %0d",
                                  out_status, out_block_index, out_total_free,
                                  want.status, want.idx, want.total));
      end
    end
  end

  // watchdog: any beat on any channel counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat for %0d cycles", STALL_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------

  // allocate and compact with nothing loaded, then a zero request
  task automatic test_empty_table();
    send_op(OP_ALLOC, 16'd5);
    // compact on an empty table leaves one entry of size zero
    send_op(OP_COMP, 16'd0);
    // zero request fits the zero-sized entry and leaves it alone
    send_op(OP_ALLOC, 16'd0);
    send_op(OP_CLEAR, 16'd0);
  endtask

  // sixteen loads with extremes and repeated sizes, then one load too many
  task automatic test_fill_to_full();
    logic [AMT_W-1:0] sizes [TABLE_DEPTH] = '{
      16'd100, 16'hFFFF, 16'd30, 16'd0, 16'd30, 16'd200, 16'hFFFF, 16'd7,
      16'd1, 16'd500, 16'd30, 16'd4096, 16'hFFFE, 16'd12, 16'd200, 16'd3};
    for (int i = 0; i < TABLE_DEPTH; i++) send_op(OP_LOAD, sizes[i]);
    send_op(OP_LOAD, 16'hFFFF);
  endtask

  // each policy on the full table, ties included, then saturating compact
  task automatic test_policy_picks();
    set_policy(FIT_FIRST);
    send_op(OP_ALLOC, 16'd30);
    set_policy(FIT_BEST);
    send_op(OP_ALLOC, 16'd30);
    set_policy(FIT_WORST);
    send_op(OP_ALLOC, 16'hFFFF);
    set_policy(FIT_UNUSED);
    send_op(OP_ALLOC, 16'd1);
    send_op(OP_COMP, 16'd0);
    send_op(OP_CLEAR, 16'd0);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly loads and allocations against a live table, with
  // sizes often taken from the table itself so exact fits and ties show up
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int n_items, input logic [1:0] code);
    int roll;
    logic [1:0] op;
    logic [AMT_W-1:0] amt;
    set_policy(code);
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(99);
      if (roll < 38) op = OP_LOAD;
      else if (roll < 86) op = OP_ALLOC;
      else if (roll < 95) op = OP_COMP;
      else op = OP_CLEAR;
      amt = AMT_W'($urandom);
      case ($urandom_range(9))
        0: amt = '0;
        1: amt = SIZE_TOP;
        2, 3: if (blk_count > 0) amt = blk_size[$urandom_range(blk_count - 1)];
        4: if (blk_count > 0) amt = blk_size[$urandom_range(blk_count - 1)] +
                                    (($urandom_range(1) != 0) ? 16'd1 : 16'hFFFF);
        5, 6: amt = AMT_W'($urandom_range(255));
        7: amt = AMT_W'($urandom_range(4095));
        default: ;
      endcase
      send_op(op, amt);
    end
  endtask

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part with the sender never idling
    gap_pct = 0;
    test_empty_table();
    test_fill_to_full();
    test_policy_picks();

    // three idle regimes, every policy in each, last chunk on a random code
    for (int r = 0; r < 3; r++) begin
      gap_pct = (r == 0) ? 38 : (r == 1) ? 56 : 0;
      test_random_traffic(ITEMS_PER_CHUNK, FIT_FIRST);
      test_random_traffic(ITEMS_PER_CHUNK, FIT_BEST);
      test_random_traffic(ITEMS_PER_CHUNK, FIT_WORST);
      test_random_traffic(ITEMS_PER_CHUNK, 2'($urandom_range(3)));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_res.size() != 0)
      note_mismatch($sformatf("%0d results never arrived", pending_res.size()));

    $display("covered %0d beats (load %0d, allocate %0d, compact %0d, clear %0d), %0d policy writes",
             n_sent, n_by_op[OP_LOAD], n_by_op[OP_ALLOC], n_by_op[OP_COMP],
             n_by_op[OP_CLEAR], n_cfg);
    $display("checked %0d results: %0d granted, %0d no fit, %0d table full, %0d mismatches",
             n_results, n_granted, n_nofit, n_full, err_count);
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
